>>> sv/stss_pkg.sv
// Package for the small table sort and search core: sizes, codes, shared types.
// No dependencies; every module of the core imports it.
package stss_pkg;

    localparam int CAPACITY   = 16;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int NAME_CHARS = 8;
    localparam int KIND_CHARS = 8;
    localparam int KEY_W      = 64;
    localparam int QTY_W      = 16;
    localparam int PRIO_W     = 3;
    localparam int CMP_W      = 8;

    localparam logic [PRIO_W-1:0] PRIO_MIN = 3'd1;
    localparam logic [PRIO_W-1:0] PRIO_MAX = 3'd5;

    localparam logic [KEY_W-1:0] NAME_MASK = {KEY_W{1'b1}} << (KEY_W - 8 * NAME_CHARS);
    localparam logic [KEY_W-1:0] KIND_MASK = {KEY_W{1'b1}} << (KEY_W - 8 * KIND_CHARS);

    // Operation codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_LIST   = 3'd2;
    localparam logic [2:0] OP_SORT   = 3'd3;
    localparam logic [2:0] OP_SEARCH = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_TOOFEW   = 3'd4;
    localparam logic [2:0] ST_UNSORTED = 3'd5;
    localparam logic [2:0] ST_BADPRIO  = 3'd6;
    localparam logic [2:0] ST_BADCRIT  = 3'd7;

    // Sort criteria
    localparam logic [1:0] CRIT_NAME = 2'd0;
    localparam logic [1:0] CRIT_KIND = 2'd1;
    localparam logic [1:0] CRIT_PRIO = 2'd2;
    localparam logic [1:0] CRIT_BAD  = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  name;
        logic [KEY_W-1:0]  kind;
        logic [QTY_W-1:0]  qty;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // Datapath commands
    localparam logic [2:0] DC_NONE    = 3'd0;
    localparam logic [2:0] DC_LATCH   = 3'd1; // capture input item
    localparam logic [2:0] DC_WRITE   = 3'd2; // store held entry at address
    localparam logic [2:0] DC_READ    = 3'd3; // read entry at address
    localparam logic [2:0] DC_SAVE    = 3'd4; // keep read entry as the moving one
    localparam logic [2:0] DC_SHIFT   = 3'd5; // write read entry at address
    localparam logic [2:0] DC_PUTMOVE = 3'd6; // write moving entry at address

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] addr;
    } t_dp_cmd;

    typedef struct packed {
        t_entry rd;        // registered read data
        logic   name_eq;   // read name equals key
        logic   name_lt;   // read name below key
        logic   sort_gt;   // read entry's sort key above moving entry's
    } t_dp_sts;

endpackage

>>> sv/small_table_sort_and_search_core.sv
// Top level of the small table sort and search core: stream ports, controller
// and datapath. Depends on stss_pkg, stss_control and stss_datapath.
//
// One operation at a time. Insert, remove (scan plus gap closing), list (one
// beat per entry), sort (compares) and search (probes) each run as steps over
// the single-port entry memory; each result beat waits in the output register
// until taken.
module small_table_sort_and_search_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[2:0], name_key[66:3], kind_key[130:67], quantity_in[146:131],
    // priority_in[149:147], criterion[151:150], sort_if_needed[152], zero fill
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], entry_index[6:3], name_out[70:7], kind_out[134:71],
    // quantity_out[150:135], priority_out[153:151], entries_held[158:154],
    // sorted_flag[159], compare_count[167:160], zero fill
    output logic [167:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    import stss_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_entry  w_item;
    t_entry  w_oent;
    logic [2:0] w_st;
    logic [IDX_W-1:0] w_idx;
    logic [CNT_W-1:0] w_held;
    logic w_sorted;
    logic [CMP_W-1:0] w_cmp;
    logic [1:0] w_crit;

    assign w_item.name = s_axis_tdata[66:3] & NAME_MASK;
    assign w_item.kind = s_axis_tdata[130:67] & KIND_MASK;
    assign w_item.qty  = s_axis_tdata[146:131];
    assign w_item.prio = s_axis_tdata[149:147];

    // A search always sorts by name
    assign w_crit = (s_axis_tdata[2:0] == OP_SEARCH) ? CRIT_NAME : s_axis_tdata[151:150];

    stss_control u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_op(s_axis_tdata[2:0]), .i_prio(s_axis_tdata[149:147]),
        .i_crit(s_axis_tdata[151:150]), .i_want_sort(s_axis_tdata[152]),
        .o_cmd(w_cmd), .i_sts(w_sts),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_status(w_st), .o_index(w_idx), .o_entry(w_oent), .o_held(w_held),
        .o_sorted(w_sorted), .o_cmp(w_cmp), .o_last(m_axis_tlast)
    );

    stss_datapath u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .i_item(w_item),
        .i_crit(w_crit), .o_sts(w_sts)
    );

    assign m_axis_tdata = {w_cmp, w_sorted, w_held, w_oent.prio, w_oent.qty,
                           w_oent.kind, w_oent.name, w_idx, w_st};

`ifndef SYNTHESIS
    // Entry count never exceeds the table size
    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_held <= CNT_W'(CAPACITY)) else $error("entry count above capacity");
    // No new item taken while a result beat is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with beat pending");
    // A full-table error beat is the last of its operation
    a_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_st == ST_FULL) |-> m_axis_tlast)
        else $error("error beat not last");
`endif

endmodule

>>> sv/stss_datapath.sv
// Datapath of the sort and search core: entry memory, captured item, moving entry
// and comparators. Depends on stss_pkg.
module stss_datapath (
    input  logic                        i_clk,
    input  stss_pkg::t_dp_cmd           i_cmd,
    input  stss_pkg::t_entry            i_item,
    input  logic [1:0]                  i_crit,
    output stss_pkg::t_dp_sts           o_sts
);
    import stss_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rd;
    t_entry r_item;
    t_entry r_move;
    logic [1:0] r_crit;
    logic [KEY_W-1:0] w_ka;
    logic [KEY_W-1:0] w_kb;

    // Memory: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DC_WRITE:   r_mem[i_cmd.addr] <= r_item;
            DC_SHIFT:   r_mem[i_cmd.addr] <= r_rd;
            DC_PUTMOVE: r_mem[i_cmd.addr] <= r_move;
            DC_READ:    r_rd <= r_mem[i_cmd.addr];
            default: ;
        endcase
    end

    // Hold the item and the entry being inserted by the sort
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DC_LATCH) begin
            r_item <= i_item;
            r_crit <= i_crit;
        end
        if (i_cmd.op == DC_SAVE) begin
            r_move <= r_rd;
        end
    end

    always_comb begin
        case (r_crit)
            CRIT_NAME: begin w_ka = r_rd.name; w_kb = r_move.name; end
            CRIT_KIND: begin w_ka = r_rd.kind; w_kb = r_move.kind; end
            default: begin
                w_ka = {{(KEY_W-PRIO_W){1'b0}}, r_rd.prio};
                w_kb = {{(KEY_W-PRIO_W){1'b0}}, r_move.prio};
            end
        endcase
    end

    assign o_sts.rd      = r_rd;
    assign o_sts.name_eq = (r_rd.name == r_item.name);
    assign o_sts.name_lt = (r_rd.name <  r_item.name);
    assign o_sts.sort_gt = (w_ka > w_kb);

endmodule

>>> sv/stss_control.sv
// Controller of the sort and search core: sequences each operation over the
// datapath and drives the result register. Depends on stss_pkg.
module stss_control (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_op,
    input  logic [stss_pkg::PRIO_W-1:0] i_prio,
    input  logic [1:0]            i_crit,
    input  logic                  i_want_sort,
    output stss_pkg::t_dp_cmd     o_cmd,
    input  stss_pkg::t_dp_sts     i_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_status,
    output logic [stss_pkg::IDX_W-1:0] o_index,
    output stss_pkg::t_entry      o_entry,
    output logic [stss_pkg::CNT_W-1:0] o_held,
    output logic                  o_sorted,
    output logic [stss_pkg::CMP_W-1:0] o_cmp,
    output logic                  o_last
);
    import stss_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_RMRD  = 4'd2;  // read entry for remove scan
    localparam logic [3:0] S_RMCHK = 4'd3;
    localparam logic [3:0] S_RMMV  = 4'd4;  // close the gap
    localparam logic [3:0] S_SOI   = 4'd5;  // sort: read entry i
    localparam logic [3:0] S_SOSV  = 4'd6;
    localparam logic [3:0] S_SOJ   = 4'd7;  // sort: read entry j
    localparam logic [3:0] S_SOCMP = 4'd8;
    localparam logic [3:0] S_SRRD  = 4'd9;  // search probe read
    localparam logic [3:0] S_SRCHK = 4'd10;
    localparam logic [3:0] S_EMRD  = 4'd11; // emit: read entry
    localparam logic [3:0] S_EMIT  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13; // wait for result taken
    localparam logic [3:0] S_RMWR  = 4'd14;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_sorted, n_sorted;
    logic [2:0]       r_op;
    logic [PRIO_W-1:0] r_prio;
    logic [1:0]       r_crit;
    logic             r_want;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W:0]   r_j, n_j;         // signed-ish: j+1 stored
    logic [CNT_W:0]   r_lo, n_lo, r_hi, n_hi;
    logic [CMP_W-1:0] r_cmp, n_cmp;
    logic             r_srch, n_srch;   // sort is the prelude of a search
    logic [3:0]       r_ret, n_ret;     // state after result accepted
    logic             r_ov, n_ov;
    logic [2:0]       r_st, n_st;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_entry           r_ent, n_ent;
    logic [CMP_W-1:0] r_ocmp, n_ocmp;
    logic             r_last, n_last;
    logic [CNT_W:0]   w_mid;
    logic [CMP_W-1:0] w_cmp_inc;

    assign w_mid = (r_lo + r_hi) >> 1;
    assign w_cmp_inc = (r_cmp == {CMP_W{1'b1}}) ? r_cmp : r_cmp + 1'b1;

    always_comb begin
        n_state = r_state; n_count = r_count; n_sorted = r_sorted;
        n_i = r_i; n_j = r_j; n_lo = r_lo; n_hi = r_hi; n_cmp = r_cmp;
        n_srch = r_srch; n_ret = r_ret;
        n_ov = r_ov; n_st = r_st; n_idx = r_idx; n_ent = r_ent;
        n_ocmp = r_ocmp; n_last = r_last;
        o_cmd = '{op: DC_NONE, addr: '0};
        o_in_ready = (r_state == S_IDLE);
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DC_LATCH;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                // defaults for a single error beat
                n_st = ST_OK; n_idx = '0; n_ent = '0; n_ocmp = '0; n_last = 1'b1;
                n_ret = S_IDLE; n_cmp = '0; n_i = '0;
                case (r_op)
                    OP_INSERT: begin
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            n_st = ST_FULL; n_ov = 1'b1; n_state = S_OUT;
                        end else if (r_prio < PRIO_MIN || r_prio > PRIO_MAX) begin
                            n_st = ST_BADPRIO; n_ov = 1'b1; n_state = S_OUT;
                        end else begin
                            o_cmd = '{op: DC_WRITE, addr: r_count[IDX_W-1:0]};
                            n_idx = r_count[IDX_W-1:0];
                            n_count = r_count + 1'b1;
                            n_sorted = 1'b0;
                            n_i = r_count;
                            n_state = S_EMRD;   // read back the stored entry
                            n_ret = S_IDLE;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_count == '0) begin
                            n_st = ST_EMPTY; n_ov = 1'b1; n_state = S_OUT;
                        end else begin
                            n_state = S_RMRD;
                        end
                    end
                    OP_LIST: begin
                        if (r_count == '0) begin
                            n_st = ST_EMPTY; n_ov = 1'b1; n_state = S_OUT;
                        end else begin
                            n_state = S_EMRD; n_ret = S_EMRD;
                        end
                    end
                    OP_SORT: begin
                        if (r_count < CNT_W'(2)) begin
                            n_st = ST_TOOFEW; n_ov = 1'b1; n_state = S_OUT;
                        end else if (r_crit == CRIT_BAD) begin
                            n_st = ST_BADCRIT; n_ov = 1'b1; n_state = S_OUT;
                        end else begin
                            n_i = CNT_W'(1); n_srch = 1'b0; n_state = S_SOI;
                        end
                    end
                    OP_SEARCH: begin
                        n_lo = '0; n_hi = {1'b0, r_count} - 1'b1;
                        if (r_count == '0) begin
                            n_st = ST_EMPTY; n_ov = 1'b1; n_state = S_OUT;
                        end else if (!r_sorted && !r_want) begin
                            n_st = ST_UNSORTED; n_ov = 1'b1; n_state = S_OUT;
                        end else if (!r_sorted) begin
                            n_i = CNT_W'(1); n_srch = 1'b1; n_state = S_SOI;
                        end else begin
                            n_state = S_SRRD;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            // Remove: scan for the first match
            S_RMRD: begin
                o_cmd = '{op: DC_READ, addr: r_i[IDX_W-1:0]};
                n_state = S_RMCHK;
            end
            S_RMCHK: begin
                if (i_sts.name_eq) begin
                    n_ent = i_sts.rd; n_idx = r_i[IDX_W-1:0];
                    n_count = r_count - 1'b1; n_sorted = 1'b0;
                    n_state = S_RMMV;
                end else if (r_i + 1'b1 == r_count) begin
                    n_st = ST_NOTFOUND; n_ov = 1'b1; n_state = S_OUT;
                end else begin
                    n_i = r_i + 1'b1; n_state = S_RMRD;
                end
            end
            S_RMMV: begin
                // r_count already decremented: move entries down to count-1
                if (r_i >= r_count) begin
                    n_ov = 1'b1; n_state = S_OUT;
                end else begin
                    o_cmd = '{op: DC_READ, addr: IDX_W'(r_i + 1'b1)};
                    n_state = S_RMWR;
                end
            end
            S_RMWR: begin
                o_cmd = '{op: DC_SHIFT, addr: r_i[IDX_W-1:0]};
                n_i = r_i + 1'b1;
                n_state = S_RMMV;
            end
            // Sort: insertion step for entry i
            S_SOI: begin
                if (r_i >= r_count) begin
                    if (r_srch) begin
                        n_sorted = 1'b1; n_state = S_SRRD;
                    end else begin
                        n_sorted = (r_crit == CRIT_NAME);
                        n_i = '0; n_state = S_EMRD; n_ret = S_EMRD;
                    end
                end else begin
                    o_cmd = '{op: DC_READ, addr: r_i[IDX_W-1:0]};
                    n_j = {1'b0, r_i};
                    n_state = S_SOSV;
                end
            end
            S_SOSV: begin
                o_cmd.op = DC_SAVE;
                n_state = S_SOJ;
            end
            S_SOJ: begin
                if (r_j == '0) begin
                    o_cmd = '{op: DC_PUTMOVE, addr: '0};
                    n_i = r_i + 1'b1; n_state = S_SOI;
                end else begin
                    o_cmd = '{op: DC_READ, addr: IDX_W'(r_j - 1'b1)};
                    n_state = S_SOCMP;
                end
            end
            S_SOCMP: begin
                n_cmp = w_cmp_inc;
                if (i_sts.sort_gt) begin
                    o_cmd = '{op: DC_SHIFT, addr: r_j[IDX_W-1:0]};
                    n_j = r_j - 1'b1; n_state = S_SOJ;
                end else begin
                    o_cmd = '{op: DC_PUTMOVE, addr: r_j[IDX_W-1:0]};
                    n_i = r_i + 1'b1; n_state = S_SOI;
                end
            end
            // Binary search
            S_SRRD: begin
                o_cmd = '{op: DC_READ, addr: w_mid[IDX_W-1:0]};
                n_cmp = '0;
                if (r_state == S_SRRD && r_srch == 1'b0) n_cmp = r_cmp;
                n_srch = 1'b0;
                n_state = S_SRCHK;
            end
            S_SRCHK: begin
                n_cmp = r_cmp + 1'b1;
                if (i_sts.name_eq) begin
                    n_ent = i_sts.rd; n_idx = w_mid[IDX_W-1:0];
                    n_ocmp = r_cmp + 1'b1; n_ov = 1'b1; n_state = S_OUT;
                end else begin
                    if (i_sts.name_lt) n_lo = w_mid + 1'b1;
                    else n_hi = w_mid - 1'b1;
                    if ((i_sts.name_lt && w_mid + 1'b1 > r_hi) ||
                        (!i_sts.name_lt && (w_mid == '0 || w_mid - 1'b1 < r_lo))) begin
                        n_st = ST_NOTFOUND; n_ocmp = r_cmp + 1'b1;
                        n_ov = 1'b1; n_state = S_OUT;
                    end else begin
                        n_state = S_SRRD;
                    end
                end
            end
            // Emit entry i (insert read-back, list, sort)
            S_EMRD: begin
                o_cmd = '{op: DC_READ, addr: r_i[IDX_W-1:0]};
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_st = ST_OK; n_ent = i_sts.rd; n_idx = r_i[IDX_W-1:0];
                n_ocmp = (r_op == OP_SORT) ? r_cmp : '0;
                n_last = (r_ret == S_IDLE) || (r_i + 1'b1 == r_count);
                n_ov = 1'b1;
                if (n_last) n_ret = S_IDLE;
                n_i = r_i + 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || i_out_ready) begin
                    n_state = r_ret;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Search counts probes from zero: clear on entry from sort or decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_sorted <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_sorted <= n_sorted; r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_j <= n_j; r_lo <= n_lo; r_hi <= n_hi;
        r_cmp <= (n_state == S_SRRD && r_state != S_SRCHK) ? '0 : n_cmp;
        r_srch <= n_srch; r_ret <= n_ret;
        r_st <= n_st; r_idx <= n_idx; r_ent <= n_ent; r_ocmp <= n_ocmp; r_last <= n_last;
        if (r_state == S_IDLE && i_in_valid) begin
            r_op <= i_op; r_prio <= i_prio; r_crit <= i_crit; r_want <= i_want_sort;
        end
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_st;
    assign o_index     = r_idx;
    assign o_entry     = r_ent;
    assign o_held      = r_count;
    assign o_sorted    = r_sorted;
    assign o_cmp       = r_ocmp;
    assign o_last      = r_last;

endmodule
